FILE: hdl/packet_flow_loss_loop_monitor_top_defines.svh
// Assertion macros shared by the checker of the flow monitor.
// No dependencies; the user must supply i_clk and i_rst_n in scope.
`ifndef PACKET_FLOW_LOSS_LOOP_MONITOR_TOP_DEFINES_SVH
`define PACKET_FLOW_LOSS_LOOP_MONITOR_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PFLM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define PFLM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/pflm_pkg.sv
// Package of the flow monitor: sizes, codes, command and status types.
// No dependencies.
package pflm_pkg;

    localparam int DEPTH   = 16;
    localparam int ID_BITS = 64;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int MAX_EV  = 3;
    localparam int TMO_W   = 16 + $clog2(DEPTH + 1);

    localparam logic [31:0] ALL32     = 32'hFFFF_FFFF;
    localparam logic [15:0] INTERVAL_RST = 16'd10;
    localparam logic [15:0] QUIET_RST    = 16'd50;

    localparam logic [2:0] FN_START  = 3'd0;
    localparam logic [2:0] FN_FINISH = 3'd1;
    localparam logic [2:0] FN_SEND   = 3'd2;
    localparam logic [2:0] FN_RECV   = 3'd3;
    localparam logic [2:0] FN_TICK   = 3'd4;

    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_START    = 3'd1;
    localparam logic [2:0] EV_FINISH   = 3'd2;
    localparam logic [2:0] EV_TRAF_ON  = 3'd3;
    localparam logic [2:0] EV_TRAF_OFF = 3'd4;
    localparam logic [2:0] EV_LOOP_ON  = 3'd5;
    localparam logic [2:0] EV_LOOP_OFF = 3'd6;
    localparam logic [2:0] EV_ERROR    = 3'd7;

    localparam logic [7:0] REG_INTERVAL = 8'd0;
    localparam logic [7:0] REG_QUIET    = 8'd1;

    typedef logic [IDX_W-1:0] t_idx;

    typedef enum logic [4:0] {
        OP_NOP, OP_ACCEPT, OP_START, OP_FINISH, OP_SEND, OP_LOOP, OP_RX_RD,
        OP_TRAF_DROP, OP_RESYNC, OP_WALK_RD, OP_WALK_NEXT, OP_WALK_SET,
        OP_MATCH, OP_SCAN_RD, OP_SCAN_NEXT, OP_ERROR, OP_TICK, OP_TICK_LOOP,
        OP_TICK_TRAF, OP_LOAD
    } t_op;

    typedef struct packed {
        logic running;
        logic loop_act;
        logic traffic_act;
        logic on_src;
        logic hit;
        logic walk_over;
        logic scan_last;
        logic due;
        logic emit_last;
    } t_status;

    function automatic logic [31:0] sat_inc32(input logic [31:0] a);
        return (a == ALL32) ? a : a + 32'd1;
    endfunction

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? ALL32 : s[31:0];
    endfunction

    function automatic t_idx idx_next(input t_idx a);
        return (a == t_idx'(DEPTH - 1)) ? '0 : a + t_idx'(1);
    endfunction

endpackage

FILE: hdl/pflm_ctrl.sv
// Sequencer of the flow monitor: decodes each word and steps the datapath.
// Depends on pflm_pkg.
module pflm_ctrl
    import pflm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [2:0] i_func,
    input  logic       i_out_ready,
    output logic       o_out_valid,
    input  t_status    i_status,
    output t_op        o_op
);

    typedef enum logic [18:0] {
        S_IDLE      = 19'b0000000000000000001,
        S_START     = 19'b0000000000000000010,
        S_FIN       = 19'b0000000000000000100,
        S_SEND      = 19'b0000000000000001000,
        S_RX        = 19'b0000000000000010000,
        S_RX_CMP    = 19'b0000000000000100000,
        S_TRAF_DROP = 19'b0000000000001000000,
        S_RESYNC    = 19'b0000000000010000000,
        S_WALK      = 19'b0000000000100000000,
        S_WALK_CMP  = 19'b0000000001000000000,
        S_MATCH     = 19'b0000000010000000000,
        S_SCAN      = 19'b0000000100000000000,
        S_SCAN_CMP  = 19'b0000001000000000000,
        S_LOOP      = 19'b0000010000000000000,
        S_ERR       = 19'b0000100000000000000,
        S_TICK      = 19'b0001000000000000000,
        S_TICK_LOOP = 19'b0010000000000000000,
        S_TICK_TRAF = 19'b0100000000000000000,
        S_EMIT      = 19'b1000000000000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        o_op        = OP_NOP;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_op = OP_ACCEPT;
                    priority if (i_func == FN_START)  n_state = S_START;
                    else if (i_func == FN_FINISH)     n_state = S_FIN;
                    else if (i_func == FN_SEND)       n_state = S_SEND;
                    else if (i_func == FN_RECV && i_status.running) n_state = S_RX;
                    else if (i_func == FN_TICK && i_status.running) n_state = S_TICK;
                    else                              n_state = S_EMIT;
                end
            end
            S_START: begin o_op = OP_START;  n_state = S_EMIT; end
            S_FIN:   begin o_op = OP_FINISH; n_state = S_EMIT; end
            S_SEND:  begin o_op = OP_SEND;   n_state = S_EMIT; end
            S_RX: begin
                priority if (i_status.on_src || i_status.loop_act) n_state = S_LOOP;
                else if (i_status.traffic_act) begin
                    o_op = OP_RX_RD;
                    n_state = S_RX_CMP;
                end else n_state = S_RESYNC;
            end
            S_RX_CMP:    n_state = i_status.hit ? S_MATCH : S_TRAF_DROP;
            S_TRAF_DROP: begin o_op = OP_TRAF_DROP; n_state = S_RESYNC; end
            S_RESYNC:    begin o_op = OP_RESYNC;    n_state = S_WALK; end
            S_WALK: begin
                if (i_status.walk_over) begin
                    o_op = OP_WALK_SET;
                    n_state = S_SCAN;
                end else begin
                    o_op = OP_WALK_RD;
                    n_state = S_WALK_CMP;
                end
            end
            S_WALK_CMP: begin
                if (i_status.hit) begin
                    o_op = OP_WALK_SET;
                    n_state = S_MATCH;
                end else begin
                    o_op = OP_WALK_NEXT;
                    n_state = S_WALK;
                end
            end
            S_MATCH: begin o_op = OP_MATCH;   n_state = S_EMIT; end
            S_SCAN:  begin o_op = OP_SCAN_RD; n_state = S_SCAN_CMP; end
            S_SCAN_CMP: begin
                priority if (i_status.hit) n_state = S_LOOP;
                else if (i_status.scan_last) n_state = S_ERR;
                else begin
                    o_op = OP_SCAN_NEXT;
                    n_state = S_SCAN;
                end
            end
            S_LOOP: begin o_op = OP_LOOP;  n_state = S_EMIT; end
            S_ERR:  begin o_op = OP_ERROR; n_state = S_FIN; end
            S_TICK: begin o_op = OP_TICK;  n_state = S_TICK_LOOP; end
            S_TICK_LOOP: begin
                if (i_status.due) begin
                    o_op = OP_TICK_LOOP;
                    n_state = S_TICK_TRAF;
                end else n_state = S_EMIT;
            end
            S_TICK_TRAF: begin o_op = OP_TICK_TRAF; n_state = S_EMIT; end
            S_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_op = OP_LOAD;
                    n_out_valid = 1'b1;
                    if (i_status.emit_last) n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

FILE: hdl/pflm_dp.sv
// Datapath of the flow monitor: ID ring, sequence numbers, timers,
// statistics, event list and result register. Depends on pflm_pkg.
module pflm_dp
    import pflm_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_op          i_op,
    output t_status      o_status,
    input  logic [63:0]  i_packet_id,
    input  logic         i_on_source_port,
    input  logic         i_cfg_we,
    input  logic [7:0]   i_cfg_index,
    input  logic [15:0]  i_cfg_data,
    output logic [2:0]   o_event_code,
    output logic [47:0]  o_event_time_ms,
    output logic         o_send_allowed,
    output logic         o_last_result,
    output logic [31:0]  o_sent_count,
    output logic [31:0]  o_received_count,
    output logic [31:0]  o_dropped_count,
    output logic [31:0]  o_interruption_count,
    output logic [31:0]  o_interruption_total_ms,
    output logic [31:0]  o_loop_count,
    output logic [31:0]  o_loop_total_ms,
    output logic         o_error_seen
);

    // ring storage; valid bits stand in for the all-zero reset contents
    logic [ID_BITS-1:0] r_ring [DEPTH];
    logic [DEPTH-1:0]   r_ring_vld;
    logic [ID_BITS-1:0] r_rd;
    logic [ID_BITS-1:0] r_id;
    logic               r_on_src;
    logic               r_allowed, n_allowed;

    logic [15:0] r_interval, n_interval, r_quiet, n_quiet;
    logic [31:0] r_tx, n_tx, r_rx, n_rx;
    t_idx        r_tx_idx, n_tx_idx, r_rx_idx, n_rx_idx;
    logic [32:0] r_walk, n_walk;
    t_idx        r_walk_idx, n_walk_idx, r_scan_idx, n_scan_idx;
    logic        r_traffic, n_traffic, r_loop, n_loop, r_running, n_running;
    logic        r_err, n_err, r_due, n_due;
    logic [31:0] r_slm, n_slm, r_slp, n_slp, r_sls, n_sls;
    logic [15:0] r_phase, n_phase;
    logic [31:0] r_sent, n_sent, r_recv, n_recv, r_drop, n_drop;
    logic [31:0] r_int_n, n_int_n, r_int_ms, n_int_ms;
    logic [31:0] r_loop_n, n_loop_n, r_loop_ms, n_loop_ms;
    logic [1:0]  r_nev, n_nev, r_emit_idx, n_emit_idx;
    logic [2:0]  r_ev_code [MAX_EV];
    logic [31:0] r_ev_seq  [MAX_EV];

    logic        push;
    logic [2:0]  push_code;
    logic [31:0] push_seq;
    logic        rd_en;
    t_idx        rd_addr;
    logic        resync;
    logic [TMO_W-1:0] tmo;
    logic        emit_last;
    logic [15:0] phase_inc;

    assign resync    = (r_tx >= 32'(DEPTH)) && (r_rx < r_tx - 32'(DEPTH));
    assign tmo       = TMO_W'(r_interval) * TMO_W'(DEPTH);
    assign emit_last = (r_nev == 2'd0) || (r_emit_idx == r_nev - 2'd1);
    assign phase_inc = r_phase + 16'd1;

    assign o_status.running     = r_running;
    assign o_status.loop_act    = r_loop;
    assign o_status.traffic_act = r_traffic;
    assign o_status.on_src      = r_on_src;
    assign o_status.hit         = (r_rd == r_id);
    assign o_status.walk_over   = (r_walk > {1'b0, r_tx});
    assign o_status.scan_last   = (r_scan_idx == t_idx'(DEPTH - 1));
    assign o_status.due         = r_due;
    assign o_status.emit_last   = emit_last;

    always_comb begin
        n_interval = r_interval; n_quiet = r_quiet;
        n_tx = r_tx; n_rx = r_rx; n_tx_idx = r_tx_idx; n_rx_idx = r_rx_idx;
        n_walk = r_walk; n_walk_idx = r_walk_idx; n_scan_idx = r_scan_idx;
        n_traffic = r_traffic; n_loop = r_loop; n_running = r_running;
        n_err = r_err; n_due = r_due;
        n_slm = r_slm; n_slp = r_slp; n_sls = r_sls; n_phase = r_phase;
        n_sent = r_sent; n_recv = r_recv; n_drop = r_drop;
        n_int_n = r_int_n; n_int_ms = r_int_ms; n_loop_n = r_loop_n; n_loop_ms = r_loop_ms;
        n_nev = r_nev; n_emit_idx = r_emit_idx; n_allowed = r_allowed;
        push = 1'b0; push_code = EV_NONE; push_seq = '0;
        rd_en = 1'b0; rd_addr = r_rx_idx;

        if (i_cfg_we) begin
            if (i_cfg_index == REG_INTERVAL) n_interval = i_cfg_data;
            if (i_cfg_index == REG_QUIET)    n_quiet    = i_cfg_data;
        end

        unique case (i_op)
            OP_NOP: ;
            OP_ACCEPT: begin
                n_nev = '0;
                n_emit_idx = '0;
                n_allowed = 1'b0;
            end
            OP_START: begin
                push = 1'b1; push_code = EV_START; push_seq = '0;
                n_traffic = 1'b0; n_loop = 1'b0;
                n_slm = '0; n_slp = '0; n_sls = '0; n_phase = '0;
                n_sent = '0; n_recv = '0; n_drop = '0;
                n_int_n = '0; n_int_ms = '0; n_loop_n = '0; n_loop_ms = '0;
                n_err = 1'b0; n_running = 1'b1;
            end
            OP_FINISH: begin
                if (r_running) begin
                    if (r_rx < r_tx || r_err) begin
                        n_int_n  = sat_inc32(r_int_n);
                        n_int_ms = sat_add32(r_int_ms, r_slm);
                    end
                    if (r_loop) begin
                        n_loop_n  = sat_inc32(r_loop_n);
                        n_loop_ms = sat_add32(r_loop_ms, r_sls);
                    end
                    push = 1'b1; push_code = EV_FINISH; push_seq = r_tx;
                    n_running = 1'b0;
                end
            end
            OP_SEND: begin
                if (r_running) begin
                    if (!r_loop) begin
                        n_sent = sat_inc32(r_sent);
                        n_allowed = 1'b1;
                    end
                    if (r_tx != ALL32) begin
                        n_tx = r_tx + 32'd1;
                        n_tx_idx = idx_next(r_tx_idx);
                    end
                end
            end
            OP_LOOP: begin
                if (!r_loop) begin
                    n_sls = '0;
                    push = 1'b1; push_code = EV_LOOP_ON; push_seq = r_tx;
                end
                n_slp = '0;
                n_loop = 1'b1;
                n_drop = sat_inc32(r_drop);
            end
            OP_RX_RD: begin
                rd_en = 1'b1; rd_addr = r_rx_idx;
            end
            OP_TRAF_DROP: begin
                push = 1'b1; push_code = EV_TRAF_OFF; push_seq = r_rx;
                n_traffic = 1'b0;
            end
            OP_RESYNC: begin
                if (resync) begin
                    n_rx = r_tx - 32'(DEPTH);
                    n_rx_idx = r_tx_idx;
                end
                n_walk = {1'b0, n_rx};
                n_walk_idx = n_rx_idx;
            end
            OP_WALK_RD: begin
                rd_en = 1'b1; rd_addr = r_walk_idx;
            end
            OP_WALK_NEXT: begin
                n_walk = r_walk + 33'd1;
                n_walk_idx = idx_next(r_walk_idx);
            end
            OP_WALK_SET: begin
                // walk past an all-ones sequence number saturates
                n_rx = r_walk[32] ? ALL32 : r_walk[31:0];
                n_rx_idx = r_walk[32] ? r_tx_idx : r_walk_idx;
                n_scan_idx = '0;
            end
            OP_MATCH: begin
                if (!r_traffic) begin
                    if (r_rx != '0) begin
                        n_int_n  = sat_inc32(r_int_n);
                        n_int_ms = sat_add32(r_int_ms, r_slm);
                    end
                    push = 1'b1; push_code = EV_TRAF_ON; push_seq = r_rx;
                    n_traffic = 1'b1;
                end
                n_slm = '0;
                n_recv = sat_inc32(r_recv);
                if (r_rx != ALL32) begin
                    n_rx = r_rx + 32'd1;
                    n_rx_idx = idx_next(r_rx_idx);
                end
            end
            OP_SCAN_RD: begin
                rd_en = 1'b1; rd_addr = r_scan_idx;
            end
            OP_SCAN_NEXT: n_scan_idx = idx_next(r_scan_idx);
            OP_ERROR: begin
                push = 1'b1; push_code = EV_ERROR; push_seq = r_rx;
                n_err = 1'b1;
            end
            OP_TICK: begin
                n_slm = sat_inc32(r_slm);
                n_slp = sat_inc32(r_slp);
                n_sls = sat_inc32(r_sls);
                n_due = (phase_inc >= r_interval);
                n_phase = n_due ? '0 : phase_inc;
            end
            OP_TICK_LOOP: begin
                if (r_loop && r_slp > {16'd0, r_quiet}) begin
                    n_loop_n  = sat_inc32(r_loop_n);
                    n_loop_ms = sat_add32(r_loop_ms, r_sls);
                    push = 1'b1; push_code = EV_LOOP_OFF; push_seq = r_tx;
                    n_loop = 1'b0;
                    n_rx = r_tx;
                    n_rx_idx = r_tx_idx;
                end
            end
            OP_TICK_TRAF: begin
                if (r_traffic && r_slm > 32'(tmo)) begin
                    push = 1'b1; push_code = EV_TRAF_OFF; push_seq = r_rx;
                    n_traffic = 1'b0;
                end
            end
            OP_LOAD: n_emit_idx = r_emit_idx + 2'd1;
            default: ;
        endcase

        if (push && r_nev != 2'(MAX_EV)) n_nev = r_nev + 2'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= INTERVAL_RST; r_quiet <= QUIET_RST;
            r_tx <= '0; r_rx <= '0; r_tx_idx <= '0; r_rx_idx <= '0;
            r_traffic <= 1'b0; r_loop <= 1'b0; r_running <= 1'b0;
            r_err <= 1'b0; r_due <= 1'b0;
            r_slm <= '0; r_slp <= '0; r_sls <= '0; r_phase <= '0;
            r_sent <= '0; r_recv <= '0; r_drop <= '0;
            r_int_n <= '0; r_int_ms <= '0; r_loop_n <= '0; r_loop_ms <= '0;
            r_nev <= '0; r_emit_idx <= '0; r_allowed <= 1'b0;
            r_ring_vld <= '0;
        end else begin
            r_interval <= n_interval; r_quiet <= n_quiet;
            r_tx <= n_tx; r_rx <= n_rx; r_tx_idx <= n_tx_idx; r_rx_idx <= n_rx_idx;
            r_traffic <= n_traffic; r_loop <= n_loop; r_running <= n_running;
            r_err <= n_err; r_due <= n_due;
            r_slm <= n_slm; r_slp <= n_slp; r_sls <= n_sls; r_phase <= n_phase;
            r_sent <= n_sent; r_recv <= n_recv; r_drop <= n_drop;
            r_int_n <= n_int_n; r_int_ms <= n_int_ms;
            r_loop_n <= n_loop_n; r_loop_ms <= n_loop_ms;
            r_nev <= n_nev; r_emit_idx <= n_emit_idx; r_allowed <= n_allowed;
            if (i_op == OP_SEND && r_running && !r_loop) r_ring_vld[r_tx_idx] <= 1'b1;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_walk <= n_walk;
        r_walk_idx <= n_walk_idx;
        r_scan_idx <= n_scan_idx;
        if (i_op == OP_ACCEPT) begin
            r_id <= i_packet_id[ID_BITS-1:0];
            r_on_src <= i_on_source_port;
        end
        if (i_op == OP_SEND && r_running && !r_loop) r_ring[r_tx_idx] <= r_id;
        if (rd_en) r_rd <= r_ring_vld[rd_addr] ? r_ring[rd_addr] : '0;
        if (push && r_nev != 2'(MAX_EV)) begin
            r_ev_code[r_nev] <= push_code;
            r_ev_seq[r_nev]  <= push_seq;
        end
        if (i_op == OP_LOAD) begin
            if (r_nev == 2'd0) begin
                o_event_code    <= EV_NONE;
                o_event_time_ms <= '0;
            end else begin
                o_event_code    <= r_ev_code[r_emit_idx];
                o_event_time_ms <= 48'(r_ev_seq[r_emit_idx]) * 48'(r_interval);
            end
            o_send_allowed          <= r_allowed;
            o_last_result           <= emit_last;
            o_sent_count            <= r_sent;
            o_received_count        <= r_recv;
            o_dropped_count         <= r_drop;
            o_interruption_count    <= r_int_n;
            o_interruption_total_ms <= r_int_ms;
            o_loop_count            <= r_loop_n;
            o_loop_total_ms         <= r_loop_ms;
            o_error_seen            <= r_err;
        end
    end

endmodule

FILE: hdl/packet_flow_loss_loop_monitor_top.sv
// Flow monitor top level: sequencer plus datapath, ports of the block.
// Depends on pflm_pkg, pflm_ctrl, pflm_dp.
//
// Takes one word at a time. A receive word that is neither a loop packet nor
// an in-order match while traffic flows walks the ID ring entry by entry
// through its single registered read port. Each result occupies the output
// register until it is taken; a word gives one to three results, the last
// flagged by o_last_result. The next word is taken once the last result of
// the current word sits in the output register. Configuration writes are
// accepted every cycle; reset leaves the ring reading as zeros.
module packet_flow_loss_loop_monitor_top
    import pflm_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    // input words
    input  logic         i_in_valid,
    output logic         o_in_ready,
    input  logic [2:0]   i_func,
    input  logic [63:0]  i_packet_id,
    input  logic         i_on_source_port,
    // result words
    output logic         o_out_valid,
    input  logic         i_out_ready,
    output logic [2:0]   o_event_code,
    output logic [47:0]  o_event_time_ms,
    output logic         o_send_allowed,
    output logic         o_last_result,
    output logic [31:0]  o_sent_count,
    output logic [31:0]  o_received_count,
    output logic [31:0]  o_dropped_count,
    output logic [31:0]  o_interruption_count,
    output logic [31:0]  o_interruption_total_ms,
    output logic [31:0]  o_loop_count,
    output logic [31:0]  o_loop_total_ms,
    output logic         o_error_seen,
    // register writes: 0 interval_ms, 1 loop_quiet_ms
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [7:0]   i_cfg_index,
    input  logic [15:0]  i_cfg_data
);

    t_op     op;
    t_status status;

    // registers are plain flops, a write never stalls
    assign o_cfg_ready = 1'b1;

    pflm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_func      (i_func),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .i_status    (status),
        .o_op        (op)
    );

    pflm_dp u_dp (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_op                    (op),
        .o_status                (status),
        .i_packet_id             (i_packet_id),
        .i_on_source_port        (i_on_source_port),
        .i_cfg_we                (i_cfg_valid),
        .i_cfg_index             (i_cfg_index),
        .i_cfg_data              (i_cfg_data),
        .o_event_code            (o_event_code),
        .o_event_time_ms         (o_event_time_ms),
        .o_send_allowed          (o_send_allowed),
        .o_last_result           (o_last_result),
        .o_sent_count            (o_sent_count),
        .o_received_count        (o_received_count),
        .o_dropped_count         (o_dropped_count),
        .o_interruption_count    (o_interruption_count),
        .o_interruption_total_ms (o_interruption_total_ms),
        .o_loop_count            (o_loop_count),
        .o_loop_total_ms         (o_loop_total_ms),
        .o_error_seen            (o_error_seen)
    );

endmodule

FILE: hdl/pflm_checker.sv
// Port-level checks of the flow monitor, bound to the top level.
// Depends on pflm_pkg and the defines header.
`include "packet_flow_loss_loop_monitor_top_defines.svh"

module pflm_checker
    import pflm_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  o_event_code,
    input logic [47:0] o_event_time_ms,
    input logic        o_send_allowed,
    input logic        o_last_result
);

    `PFLM_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid, "result dropped")
    `PFLM_ASSERT_NEXT(a_one_at_a_time, i_in_valid && o_in_ready, !o_in_ready, "word overlap")
    `PFLM_ASSERT_NOW(a_none_no_time, o_out_valid && o_event_code == EV_NONE, o_event_time_ms == '0, "time on empty result")
    `PFLM_ASSERT_NOW(a_send_no_event, o_out_valid && o_send_allowed, o_event_code == EV_NONE, "event on send")
    `PFLM_ASSERT_NOW(a_error_not_last, o_out_valid && o_event_code == EV_ERROR, !o_last_result, "error without finish")

endmodule

bind packet_flow_loss_loop_monitor_top pflm_checker u_pflm_checker (.*);

FILE: dv/tb.sv
// Self-checking testbench of packet_flow_loss_loop_monitor_top: a random and
// directed packet flow against a behavioral predictor of the monitor.
// Depends on pflm_pkg and the RTL of the block only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pflm_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 100;   // covers the longest receive walk

    typedef struct {
        logic [2:0]  func;
        logic [63:0] id;
        logic        src;
    } flow_word_t;

    typedef struct {
        logic [2:0]  code;
        logic [47:0] tstamp;
        logic        allowed;
        logic        last;
        logic [31:0] cnt [7];
        logic        err;
    } flow_result_t;

    // statistics slots, in port order
    localparam int S_SENT = 0, S_RECV = 1, S_DROP = 2, S_INT_N = 3, S_INT_MS = 4,
                   S_LOOP_N = 5, S_LOOP_MS = 6;

    logic        i_clk, i_rst_n;
    logic        i_in_valid, o_in_ready;
    logic [2:0]  i_func;
    logic [63:0] i_packet_id;
    logic        i_on_source_port;
    logic        o_out_valid, i_out_ready;
    logic [2:0]  o_event_code;
    logic [47:0] o_event_time_ms;
    logic        o_send_allowed, o_last_result;
    logic [31:0] o_sent_count, o_received_count, o_dropped_count;
    logic [31:0] o_interruption_count, o_interruption_total_ms;
    logic [31:0] o_loop_count, o_loop_total_ms;
    logic        o_error_seen;
    logic        i_cfg_valid, o_cfg_ready;
    logic [7:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    packet_flow_loss_loop_monitor_top uut (.*);

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------------
    // Predictor: mirror of the monitor state, advanced once per accepted word
    // ---------------------------------------------------------------------
    logic [15:0] mon_interval, mon_quiet;
    logic [63:0] id_ring [DEPTH];
    logic [31:0] tx_seq, rx_seq;
    bit          traffic_on, loop_on, running, err_flag;
    logic [31:0] ms_since_match, ms_since_loop_pkt, ms_since_loop_start;
    logic [31:0] check_phase;
    logic [31:0] flow_stats [7];

    int          ev_n;
    logic [2:0]  ev_codes [MAX_EV];
    logic [47:0] ev_times [MAX_EV];

    flow_result_t pending_results [$];

    function automatic logic [31:0] bump(logic [31:0] a);
        return (a == 32'hFFFF_FFFF) ? a : a + 32'd1;
    endfunction

    function automatic logic [31:0] accum(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    task automatic note_event(logic [2:0] code, logic [31:0] seq);
        if (ev_n < MAX_EV) begin
            ev_codes[ev_n] = code;
            ev_times[ev_n] = 48'(seq) * 48'(mon_interval);
            ev_n++;
        end
    endtask

    task automatic close_test();
        if (!running) return;
        if (rx_seq < tx_seq || err_flag) begin
            flow_stats[S_INT_N]  = bump(flow_stats[S_INT_N]);
            flow_stats[S_INT_MS] = accum(flow_stats[S_INT_MS], ms_since_match);
        end
        if (loop_on) begin
            flow_stats[S_LOOP_N]  = bump(flow_stats[S_LOOP_N]);
            flow_stats[S_LOOP_MS] = accum(flow_stats[S_LOOP_MS], ms_since_loop_start);
        end
        note_event(EV_FINISH, tx_seq);
        running = 0;
    endtask

    task automatic mark_loop();
        if (!loop_on) begin
            ms_since_loop_start = 0;
            note_event(EV_LOOP_ON, tx_seq);
        end
        ms_since_loop_pkt = 0;
        loop_on = 1;
        flow_stats[S_DROP] = bump(flow_stats[S_DROP]);
    endtask

    task automatic in_order_match();
        if (!traffic_on) begin
            if (rx_seq > 0) begin
                flow_stats[S_INT_N]  = bump(flow_stats[S_INT_N]);
                flow_stats[S_INT_MS] = accum(flow_stats[S_INT_MS], ms_since_match);
            end
            note_event(EV_TRAF_ON, rx_seq);
            traffic_on = 1;
        end
        ms_since_match = 0;
        flow_stats[S_RECV] = bump(flow_stats[S_RECV]);
        rx_seq = bump(rx_seq);
    endtask

    task automatic packet_back(logic [63:0] id, logic src);
        logic [32:0] r;
        bit known;
        if (src || loop_on) begin
            mark_loop();
            return;
        end
        if (traffic_on) begin
            if (id_ring[rx_seq % DEPTH] == id) begin
                in_order_match();
                return;
            end
            note_event(EV_TRAF_OFF, rx_seq);
            traffic_on = 0;
        end
        // resync window: never look further back than the ring holds
        if (tx_seq >= DEPTH && rx_seq < tx_seq - DEPTH) rx_seq = tx_seq - DEPTH;
        r = {1'b0, rx_seq};
        while (r <= {1'b0, tx_seq} && id_ring[r % DEPTH] != id) r++;
        rx_seq = r[32] ? 32'hFFFF_FFFF : r[31:0];
        if (r > {1'b0, tx_seq}) begin
            known = 0;
            foreach (id_ring[i]) if (id_ring[i] == id) known = 1;
            if (known) mark_loop();
            else begin
                note_event(EV_ERROR, rx_seq);
                err_flag = 1;
                close_test();
            end
        end else in_order_match();
    endtask

    task automatic ms_tick();
        ms_since_match      = bump(ms_since_match);
        ms_since_loop_pkt   = bump(ms_since_loop_pkt);
        ms_since_loop_start = bump(ms_since_loop_start);
        check_phase++;
        if (check_phase < 32'(mon_interval)) return;
        check_phase = 0;
        if (loop_on && ms_since_loop_pkt > 32'(mon_quiet)) begin
            flow_stats[S_LOOP_N]  = bump(flow_stats[S_LOOP_N]);
            flow_stats[S_LOOP_MS] = accum(flow_stats[S_LOOP_MS], ms_since_loop_start);
            note_event(EV_LOOP_OFF, tx_seq);
            loop_on = 0;
            rx_seq = tx_seq;
        end
        if (traffic_on && 64'(ms_since_match) > 64'(mon_interval) * DEPTH) begin
            note_event(EV_TRAF_OFF, rx_seq);
            traffic_on = 0;
        end
    endtask

    task automatic predict_word(flow_word_t w);
        bit allowed;
        int n;
        flow_result_t res;
        allowed = 0;
        ev_n = 0;
        case (w.func)
            FN_START: begin
                note_event(EV_START, 0);
                traffic_on = 0;
                loop_on = 0;
                ms_since_match = 0;
                ms_since_loop_pkt = 0;
                ms_since_loop_start = 0;
                check_phase = 0;
                foreach (flow_stats[i]) flow_stats[i] = 0;
                err_flag = 0;
                running = 1;
            end
            FN_FINISH: close_test();
            FN_SEND: if (running) begin
                if (!loop_on) begin
                    id_ring[tx_seq % DEPTH] = w.id;
                    flow_stats[S_SENT] = bump(flow_stats[S_SENT]);
                    allowed = 1;
                end
                tx_seq = bump(tx_seq);
            end
            FN_RECV: if (running) packet_back(w.id, w.src);
            FN_TICK: if (running) ms_tick();
            default: ;
        endcase
        n = (ev_n > 0) ? ev_n : 1;
        for (int k = 0; k < n; k++) begin
            res.code    = (ev_n > 0) ? ev_codes[k] : EV_NONE;
            res.tstamp  = (ev_n > 0) ? ev_times[k] : '0;
            res.allowed = allowed;
            res.last    = (k == n - 1);
            res.cnt     = flow_stats;
            res.err     = err_flag;
            pending_results.insert(pending_results.size(), res);
        end
    endtask

    // ---------------------------------------------------------------------
    // Driver: feeds words from the stimulus queue, outside burst mode a random gap after each
    // ---------------------------------------------------------------------
    flow_word_t word_queue [$];
    flow_word_t cur_word;
    bit         hold_sender;   // stimulus thread blocks new words while set
    bit         no_idle;       // burst mode: no gaps, no stalls
    int         send_gap;
    int         words_accepted, results_seen, mismatches, idle_cycles;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid       <= 1'b0;
            i_func           <= FN_TICK;
            i_packet_id      <= '0;
            i_on_source_port <= 1'b0;
            send_gap         <= 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                cur_word.func = i_func;
                cur_word.id   = i_packet_id;
                cur_word.src  = i_on_source_port;
                predict_word(cur_word);
                words_accepted++;
            end
            // slot is free when nothing is held or the held word just went
            if (!i_in_valid || o_in_ready) begin
                if (send_gap != 0) begin
                    send_gap   <= send_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (word_queue.size() > 0 && !hold_sender) begin
                    cur_word = word_queue.pop_front();
                    i_func           <= cur_word.func;
                    i_packet_id      <= cur_word.id;
                    i_on_source_port <= cur_word.src;
                    i_in_valid       <= 1'b1;
                    send_gap         <= no_idle ? 0 : $urandom_range(0, 7);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Monitor: random receive stalls outside burst mode, field-by-field compare, oldest first
    // ---------------------------------------------------------------------
    int stall_left;

    function automatic bit same_result(flow_result_t e);
        return o_event_code == e.code && o_event_time_ms == e.tstamp &&
               o_send_allowed == e.allowed && o_last_result == e.last &&
               o_sent_count == e.cnt[S_SENT] && o_received_count == e.cnt[S_RECV] &&
               o_dropped_count == e.cnt[S_DROP] &&
               o_interruption_count == e.cnt[S_INT_N] &&
               o_interruption_total_ms == e.cnt[S_INT_MS] &&
               o_loop_count == e.cnt[S_LOOP_N] && o_loop_total_ms == e.cnt[S_LOOP_MS] &&
               o_error_seen == e.err;
    endfunction

    always @(posedge i_clk) begin
        flow_result_t exp_res;
        int nxt;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_left  <= 0;
        end else begin
            nxt = stall_left;
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] unexpected result word, code %0d", $realtime,
                                 o_event_code);
                end else begin
                    exp_res = pending_results.pop_front();
                    if (!same_result(exp_res)) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("[%0t] mismatch exp: ev=%0d t=%0d ok=%0d last=%0d",
                                     $realtime, exp_res.code, exp_res.tstamp,
                                     exp_res.allowed, exp_res.last);
                            $display("    cnt=%p err=%0d", exp_res.cnt, exp_res.err);
                            $display("  act: ev=%0d t=%0d ok=%0d last=%0d", o_event_code,
                                     o_event_time_ms, o_send_allowed, o_last_result);
                            $display("    cnt='{%0d, %0d, %0d, %0d, %0d, %0d, %0d} err=%0d",
                                     o_sent_count, o_received_count, o_dropped_count,
                                     o_interruption_count, o_interruption_total_ms,
                                     o_loop_count, o_loop_total_ms, o_error_seen);
                        end
                    end
                end
                nxt = no_idle ? 0 : $urandom_range(0, 7);
            end else if (nxt != 0) begin
                nxt = nxt - 1;
            end
            stall_left  <= nxt;
            i_out_ready <= (nxt == 0);
        end
    end

    // Watchdog: cycles with no handshake on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------
    task automatic add_word(logic [2:0] f, logic [63:0] id = '0, logic src = 1'b0);
        flow_word_t w;
        w.func = f;
        w.id   = id;
        w.src  = src;
        word_queue.insert(word_queue.size(), w);
    endtask

    function automatic logic [63:0] rand_id();
        return {$urandom(), $urandom()};
    endfunction

    // waits until the block has drained, then covers the tail latency
    task automatic drain();
        while (word_queue.size() > 0 || i_in_valid || pending_results.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [7:0] idx, logic [15:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == REG_INTERVAL) mon_interval = val;
        else mon_quiet = val;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic configure(logic [15:0] interval, logic [15:0] quiet);
        drain();
        write_reg(REG_INTERVAL, interval);
        write_reg(REG_QUIET, quiet);
    endtask

    // A test session: mostly a well-formed send/receive/tick flow with losses,
    // loops and errors mixed in, plus some noise words.
    task automatic random_flow(int n_words, int long_burst);
        logic [63:0] sent_ids [$];
        int next_rx, pick, cnt, j;
        next_rx = 0;
        add_word(FN_START);
        cnt = 1;
        while (cnt < n_words) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                sent_ids.insert(sent_ids.size(),
                                ($urandom_range(0, 9) == 0) ? 64'(pick) : rand_id());
                add_word(FN_SEND, sent_ids[$]);
            end else if (pick < 60 && next_rx < sent_ids.size()) begin
                // in order, sometimes after a few lost packets
                if (pick >= 54) next_rx += $urandom_range(1, 3);
                if (next_rx >= sent_ids.size()) next_rx = sent_ids.size() - 1;
                add_word(FN_RECV, sent_ids[next_rx]);
                next_rx++;
            end else if (pick < 64) begin
                add_word(FN_RECV, rand_id(), 1'b1);
            end else if (pick < 67 && sent_ids.size() > 0) begin
                add_word(FN_RECV, sent_ids[$urandom_range(0, sent_ids.size() - 1)]);
            end else if (pick < 69) begin
                add_word(FN_RECV, rand_id());
                add_word(FN_START);
                cnt++;
            end else if (pick < 92) begin
                j = ($urandom_range(0, 19) == 0) ? long_burst : $urandom_range(1, 6);
                repeat (j) add_word(FN_TICK);
                cnt += j - 1;
            end else if (pick < 95) begin
                add_word(FN_FINISH);
                add_word(FN_START);
                cnt++;
            end else begin
                add_word(3'($urandom_range(0, 7)), rand_id(), 1'($urandom_range(0, 1)));
            end
            cnt++;
        end
        add_word(FN_FINISH);
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_INTERVAL;
        i_cfg_data  = '0;
        hold_sender = 0;
        no_idle     = 0;
        words_accepted = 0;
        results_seen = 0;
        mismatches   = 0;
        idle_cycles  = 0;
        mon_interval = INTERVAL_RST;
        mon_quiet    = QUIET_RST;
        foreach (id_ring[i]) id_ring[i] = '0;
        tx_seq = 0; rx_seq = 0;
        traffic_on = 0; loop_on = 0; running = 0; err_flag = 0;
        ms_since_match = 0; ms_since_loop_pkt = 0; ms_since_loop_start = 0;
        check_phase = 0;
        foreach (flow_stats[i]) flow_stats[i] = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: idle-state words, extremes of the ID, every func code
        add_word(FN_SEND, '1);                  // not running: refused
        add_word(FN_RECV, '1, 1'b1);            // not running: ignored
        add_word(FN_TICK);
        add_word(FN_FINISH);                    // finish with no test
        add_word(3'd5, '1, 1'b1);               // undefined codes
        add_word(3'd6);
        add_word(3'd7);
        add_word(FN_START);
        add_word(FN_SEND, '1);
        add_word(FN_SEND, '0);
        add_word(FN_SEND, 64'h8000_0000_0000_0001);
        add_word(FN_RECV, '1);                  // traffic starts
        add_word(FN_RECV, 64'h8000_0000_0000_0001); // one lost, resync
        add_word(FN_RECV, 64'h1234_5678_9ABC_DEF0, 1'b1); // back on source port
        add_word(FN_SEND, 64'h55);              // refused during loop
        add_word(FN_RECV, '1);                  // loop packet
        add_word(FN_START);                     // restart while running
        add_word(FN_RECV, '1);                  // consumed ID: loop
        add_word(FN_START);
        add_word(FN_RECV, 64'hDEAD_BEEF_0BAD_F00D); // unknown: error ends test
        add_word(FN_FINISH);
        random_flow(50, 70);

        // sender pauses mid-run until every result is in
        while (word_queue.size() > 20) @(posedge i_clk);
        hold_sender = 1;
        while (i_in_valid || pending_results.size() > 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        hold_sender = 0;

        configure(16'd1, 16'd1);
        no_idle = 1;
        random_flow(30, 20);
        drain();
        no_idle = 0;
        random_flow(30, 20);

        configure(16'd0, 16'd0);               // timers checked on every tick
        random_flow(40, 10);

        configure(16'hFFFF, 16'hFFFF);
        random_flow(40, 30);

        configure(16'd2, 16'd5);
        random_flow(60, 40);

        drain();
        $display("%0d input words, %0d result words checked over five register settings",
                 words_accepted, results_seen);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches, %0d results outstanding", mismatches,
                     pending_results.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
